### rtl/core/sha1md_pkg.sv
// Shared types and constants for the SHA-1 digest engine.
package sha1md_pkg;

    typedef logic [4:0][31:0] t_words;

    typedef struct packed {
        logic [31:0] msg_word;
        logic [2:0]  valid_bytes;
        logic        end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // control from the sequencer to the schedule window
    typedef struct packed {
        logic       push;    // one message or pad byte enters
        logic [7:0] data;
        logic       commit;  // fourth byte of a word: word enters the window
        logic       rnd;     // round cycle: window advances by one word
        logic       expand;  // round 16 and later: use the expanded word
    } t_sched_ctl;

    localparam t_words INIT_H = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                 32'hEFCDAB89, 32'h67452301};

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] FILL_LEN   = 6'd55;   // next byte lands at offset 56
    localparam logic [2:0] BYTES_MAX  = 3'd4;
    localparam logic [2:0] WORD_LAST  = 3'd4;
    localparam logic [2:0] LEN_LAST   = 3'd7;

    function automatic logic [31:0] round_k(input logic [1:0] grp);
        logic [31:0] k;
        case (grp)
            2'd0:    k = 32'h5A827999;
            2'd1:    k = 32'h6ED9EBA1;
            2'd2:    k = 32'h8F1BBCDC;
            default: k = 32'hCA62C1D6;
        endcase
        return k;
    endfunction

endpackage

### rtl/core/sha1md_round.sv
// SHA-1 round datapath, shared by all 80 rounds.
module sha1md_round (
    input  sha1md_pkg::t_words i_vars,
    input  logic [31:0]        i_w,
    input  logic [1:0]         i_grp,
    output sha1md_pkg::t_words o_vars
);
    import sha1md_pkg::*;

    logic [31:0] a, b, c, d, e, f, tmp;

    assign a = i_vars[0];
    assign b = i_vars[1];
    assign c = i_vars[2];
    assign d = i_vars[3];
    assign e = i_vars[4];

    always_comb begin
        case (i_grp)
            2'd0:    f = (b & c) | (~b & d);
            2'd2:    f = (b & c) | (b & d) | (c & d);
            default: f = b ^ c ^ d;
        endcase
    end

    assign tmp = {a[26:0], a[31:27]} + f + e + i_w + round_k(i_grp);

    assign o_vars = {d, c, {b[1:0], b[31:2]}, a, tmp};

endmodule

### rtl/core/sha1md_sched.sv
// Byte packer and 16-word message schedule shift line.
module sha1md_sched (
    input  logic                   i_clk,
    input  sha1md_pkg::t_sched_ctl i_ctl,
    output logic [31:0]            o_w
);
    import sha1md_pkg::*;

    logic [31:0]       r_acc;
    logic [15:0][31:0] r_win;   // [0] is the oldest word
    logic [31:0]       n_acc;
    logic [31:0]       mix;
    logic [31:0]       shift_in;

    assign n_acc = {r_acc[23:0], i_ctl.data};

    // W[t-3] ^ W[t-8] ^ W[t-14] ^ W[t-16]
    assign mix = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
    assign o_w = i_ctl.expand ? {mix[30:0], mix[31]} : r_win[0];

    assign shift_in = i_ctl.rnd ? o_w : n_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_acc <= n_acc;
        end
        if (i_ctl.rnd || (i_ctl.push && i_ctl.commit)) begin
            r_win <= {shift_in, r_win[15:1]};
        end
    end

endmodule

### rtl/core/sha1_message_digest.sv
// SHA-1 digest engine: byte sequencer, round control and digest output.
// An item's valid bytes enter one byte per cycle, paused while a full block is compressed.
// Each full 64-byte block adds 80 passes of the shared round unit and one fold.
// End of message adds 9 to 72 pad bytes, one or two blocks, then the five digest words.
// A new item is taken only in the idle state, once the bytes of the last one have entered.
// Synchronous active-low reset loads H0..H4 and clears the counts and the sequencer.
module sha1_message_digest (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sha1md_pkg::t_in_item i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sha1md_pkg::t_out_item o_out_data
);
    import sha1md_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MSG   = 8'b0000_0010,
        S_MARK  = 8'b0000_0100,
        S_ZERO  = 8'b0000_1000,
        S_LEN   = 8'b0001_0000,
        S_ROUND = 8'b0010_0000,
        S_FOLD  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state      r_state, n_state, r_resume, n_resume, after;
    logic [31:0] r_word, n_word;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_eom, n_eom;
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_count, n_count;
    logic [2:0]  r_len_idx, n_len_idx;
    logic [6:0]  r_round, n_round;
    logic [2:0]  r_out_idx, n_out_idx;
    t_words      r_vars, n_vars, r_chain, n_chain, round_out;

    logic        push;
    logic [7:0]  push_data;
    logic [63:0] len_sh;
    logic [1:0]  grp;
    logic [31:0] w;
    t_sched_ctl  sched_ctl;

    assign len_sh = {r_count, 3'b000} << {r_len_idx, 3'b000};

    always_comb begin
        if (r_round < 7'd20)      grp = 2'd0;
        else if (r_round < 7'd40) grp = 2'd1;
        else if (r_round < 7'd60) grp = 2'd2;
        else                      grp = 2'd3;
    end

    assign sched_ctl = '{push:   push,
                         data:   push_data,
                         commit: (r_fill[1:0] == 2'd3),
                         rnd:    (r_state == S_ROUND),
                         expand: (r_round[6:4] != 3'd0)};

    sha1md_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sched_ctl),
        .o_w   (w)
    );

    sha1md_round u_round (
        .i_vars (r_vars),
        .i_w    (w),
        .i_grp  (grp),
        .o_vars (round_out)
    );

    always_comb begin
        n_state   = r_state;
        n_resume  = r_resume;
        n_word    = r_word;
        n_cnt     = r_cnt;
        n_eom     = r_eom;
        n_fill    = r_fill;
        n_count   = r_count;
        n_len_idx = r_len_idx;
        n_round   = r_round;
        n_out_idx = r_out_idx;
        n_vars    = r_vars;
        n_chain   = r_chain;
        push      = 1'b0;
        push_data = 8'h00;
        after     = r_state;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_word  = i_in_data.msg_word;
                    n_cnt   = (i_in_data.valid_bytes > BYTES_MAX) ? BYTES_MAX
                                                                  : i_in_data.valid_bytes;
                    n_eom   = i_in_data.end_of_message;
                    n_state = S_MSG;
                end
            end
            S_MSG: begin
                if (r_cnt == 3'd0) begin
                    n_state = r_eom ? S_MARK : S_IDLE;
                end else begin
                    push      = 1'b1;
                    push_data = r_word[31:24];
                    n_word    = {r_word[23:0], 8'h00};
                    n_cnt     = r_cnt - 3'd1;
                    n_count   = r_count + 61'd1;
                    if (r_cnt == 3'd1) after = r_eom ? S_MARK : S_IDLE;
                    else               after = S_MSG;
                end
            end
            S_MARK: begin
                push      = 1'b1;
                push_data = PAD_MARK;
                after     = (r_fill == FILL_LEN) ? S_LEN : S_ZERO;
            end
            S_ZERO: begin
                push      = 1'b1;
                push_data = 8'h00;
                after     = (r_fill == FILL_LEN) ? S_LEN : S_ZERO;
            end
            S_LEN: begin
                push      = 1'b1;
                push_data = len_sh[63:56];
                n_len_idx = r_len_idx + 3'd1;
                after     = (r_len_idx == LEN_LAST) ? S_OUT : S_LEN;
            end
            S_ROUND: begin
                n_vars  = round_out;
                n_round = r_round + 7'd1;
                if (r_round == ROUND_LAST) begin
                    n_round = 7'd0;
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                for (int k = 0; k < 5; k++) begin
                    n_chain[k] = r_chain[k] + r_vars[k];
                end
                n_state = r_resume;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (r_out_idx == WORD_LAST) begin
                        n_out_idx = 3'd0;
                        n_chain   = INIT_H;
                        n_count   = '0;
                        n_fill    = '0;
                        n_len_idx = '0;
                        n_round   = '0;
                        n_state   = S_IDLE;
                    end else begin
                        n_out_idx = r_out_idx + 3'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (push) begin
            n_fill = r_fill + 6'd1;
            if (r_fill == FILL_LAST) begin
                // block complete: compress, then continue where we were
                n_state  = S_ROUND;
                n_resume = after;
                n_vars   = r_chain;
                n_round  = 7'd0;
            end else begin
                n_state = after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_resume  <= S_IDLE;
            r_cnt     <= '0;
            r_eom     <= 1'b0;
            r_fill    <= '0;
            r_count   <= '0;
            r_len_idx <= '0;
            r_round   <= '0;
            r_out_idx <= '0;
            r_chain   <= INIT_H;
        end else begin
            r_state   <= n_state;
            r_resume  <= n_resume;
            r_cnt     <= n_cnt;
            r_eom     <= n_eom;
            r_fill    <= n_fill;
            r_count   <= n_count;
            r_len_idx <= n_len_idx;
            r_round   <= n_round;
            r_out_idx <= n_out_idx;
            r_chain   <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_vars <= n_vars;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = '{digest_word: r_chain[r_out_idx],
                           word_index:  r_out_idx,
                           last_word:   (r_out_idx == WORD_LAST)};

    a_round_block_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_fill == 6'd0))
        else $error("compression running with a partly filled block");

    a_round_to_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round == ROUND_LAST) |=> (r_state == S_FOLD))
        else $error("last round not followed by chain fold");

    a_rearm_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.last_word)
        |=> (r_state == S_IDLE && r_count == 61'd0 && r_fill == 6'd0
             && r_chain == INIT_H))
        else $error("engine not rearmed after final digest word");

    a_out_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_out_idx <= WORD_LAST))
        else $error("digest word index out of range");

endmodule

### test/testbench.sv
// Testbench for the SHA-1 digest engine: directed and random messages checked against a built-in SHA-1 model.
`timescale 1ns / 100ps

module testbench;
    import sha1md_pkg::*;

    localparam int GAP_MAX      = 18;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_ITEMS = 350;
    localparam int REPORT_MAX   = 10;

    // Digest predictor and queue of digest words still owed by the block.
    class sha1_digest_model;
        logic [31:0] chain[5];
        logic [31:0] window[16];
        logic [60:0] byte_count;
        int          fill;
        t_out_item   pending_digests[$];
        int          mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            for (int k = 0; k < 5; k++) chain[k] = INIT_H[k];
            for (int k = 0; k < 16; k++) window[k] = '0;
            byte_count = '0;
            fill = 0;
        endfunction

        function logic [31:0] rotl(logic [31:0] v, int s);
            return (v << s) | (v >> (32 - s));
        endfunction

        function void compress_block();
            logic [31:0] a, b, c, d, e, f, k, w, tmp;
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
            for (int t = 0; t < 80; t++) begin
                if (t < 16) begin
                    w = window[t];
                end else begin
                    w = rotl(window[(t - 3) % 16] ^ window[(t - 8) % 16] ^
                             window[(t - 14) % 16] ^ window[t % 16], 1);
                    window[t % 16] = w;
                end
                if (t < 20) begin
                    f = (b & c) | (~b & d);
                    k = 32'h5A827999;
                end else if (t < 40) begin
                    f = b ^ c ^ d;
                    k = 32'h6ED9EBA1;
                end else if (t < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = 32'h8F1BBCDC;
                end else begin
                    f = b ^ c ^ d;
                    k = 32'hCA62C1D6;
                end
                tmp = rotl(a, 5) + f + e + w + k;
                e = d;
                d = c;
                c = rotl(b, 30);
                b = a;
                a = tmp;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
        endfunction

        function void push_byte(logic [7:0] data);
            window[fill / 4][(3 - fill % 4) * 8 +: 8] = data;
            fill++;
            if (fill == 64) begin
                fill = 0;
                compress_block();
            end
        endfunction

        function void absorb_request(t_in_item req);
            int          nbytes;
            logic [63:0] bit_len;
            t_out_item   dw;
            nbytes = (req.valid_bytes > BYTES_MAX) ? BYTES_MAX : req.valid_bytes;
            for (int i = 0; i < nbytes; i++) begin
                push_byte(req.msg_word[31 - 8 * i -: 8]);
                byte_count++;
            end
            if (!req.end_of_message) return;
            bit_len = {byte_count, 3'b000};
            push_byte(PAD_MARK);
            while (fill != 56) push_byte(8'h00);
            for (int i = 0; i < 8; i++) push_byte(bit_len[63 - 8 * i -: 8]);
            for (int k = 0; k < 5; k++) begin
                dw.digest_word = chain[k];
                dw.word_index  = 3'(k);
                dw.last_word   = (3'(k) == WORD_LAST);
                pending_digests.push_back(dw);
            end
            restart();
        endfunction

        function void check_digest_word(t_out_item got);
            t_out_item want;
            if (pending_digests.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected digest word %h idx %0d last %0b",
                             got.digest_word, got.word_index, got.last_word);
                return;
            end
            want = pending_digests.pop_front();
            if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
                got.last_word !== want.last_word) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("digest mismatch: want %h idx %0d last %0b, got %h idx %0d last %0b",
                             want.digest_word, want.word_index, want.last_word,
                             got.digest_word, got.word_index, got.last_word);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    t_in_item  req_data;
    logic      dig_valid;
    logic      dig_stall;
    t_out_item dig_data;

    sha1_digest_model model;
    int  item_count;
    int  idle_cycles = 0;
    bit  req_quiet;
    bit  dig_quiet;

    sha1_message_digest u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (req_valid),
        .o_in_stall   (req_stall),
        .i_in_data    (req_data),
        .o_out_valid  (dig_valid),
        .i_out_stall  (dig_stall),
        .o_out_data   (dig_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // quiet stretches with no idling, toggled now and then
    function automatic int draw_gap(ref bit quiet);
        if ($urandom_range(0, 15) == 0) quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic [31:0] word, input int nbytes, input bit eom);
        t_in_item req;
        int       gap;
        req.msg_word       = word;
        req.valid_bytes    = 3'(nbytes);
        req.end_of_message = eom;
        gap = draw_gap(req_quiet);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_data  <= req;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        model.absorb_request(req);
        // a zero-byte item without end mark is dropped by the block
        if (eom || nbytes != 0) item_count++;
        @(negedge clk);
    endtask

    task automatic send_message(input int n_items);
        int nbytes;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 9) < 6) nbytes = BYTES_MAX;
            else nbytes = $urandom_range(0, 7);
            send_request($urandom, nbytes, i == n_items - 1);
        end
    endtask

    // digest receiver
    initial begin
        int gap;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            gap = draw_gap(dig_quiet);
            if (gap > 0) begin
                dig_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            dig_stall <= 1'b0;
            @(posedge clk);
            while (!dig_valid) @(posedge clk);
            model.check_digest_word(dig_data);
            @(negedge clk);
        end
    end

    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (dig_valid && !dig_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        model       = new();
        item_count  = 0;
        req_quiet   = 1'b0;
        dig_quiet   = 1'b0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_data    = '0;
        dig_stall   = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty message
        send_request(32'h0000_0000, 0, 1'b1);
        // byte count above four saturates
        send_request(32'hFFFF_FFFF, 7, 1'b1);
        // unaligned packing, an ignored empty item, saturation mid-message
        send_request(32'h0000_0000, 1, 1'b0);
        send_request(32'hDEAD_BEEF, 0, 1'b0);
        send_request(32'hFFFF_FFFF, 5, 1'b0);
        send_request(32'h8000_0001, 2, 1'b0);
        send_request(32'h1234_5678, 6, 1'b1);
        // 56 bytes: length no longer fits, padding spills into a second block
        for (int i = 0; i < 14; i++)
            send_request((i % 3 == 0) ? 32'h0000_0000 : (i % 3 == 1) ? 32'hFFFF_FFFF : $urandom,
                         BYTES_MAX, i == 13);

        item_count = 0;
        while (item_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) send_message($urandom_range(14, 40));
            else send_message($urandom_range(1, 20));
        end
        req_valid <= 1'b0;

        while (model.pending_digests.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (model.mismatches == 0 && model.pending_digests.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
